// ===== rtl/iscpc_pkg.sv =====
`default_nettype none

package iscpc_pkg;

	// source store geometry
	localparam int SRC_BYTES   = 16384;
	localparam int BANKS       = 4;
	localparam int BANK_DEPTH  = (SRC_BYTES + BANKS - 1) / BANKS;
	localparam int ROW_W       = $clog2(BANK_DEPTH);
	localparam int PIX_ADDR_W  = 22;

	// item kinds
	localparam logic FUNC_WRITE   = 1'b0;
	localparam logic FUNC_REQUEST = 1'b1;

	// register indexes
	localparam logic [2:0] CFG_OUT_FORMAT      = 3'd0;
	localparam logic [2:0] CFG_SRC_FORMAT      = 3'd1;
	localparam logic [2:0] CFG_SRC_PIXEL_BYTES = 3'd2;
	localparam logic [2:0] CFG_SRC_WIDTH       = 3'd3;
	localparam logic [2:0] CFG_SRC_HEIGHT      = 3'd4;
	localparam logic [2:0] CFG_SRC_ROW_BYTES   = 3'd5;
	localparam logic [2:0] CFG_SCALE_Q16       = 3'd6;

	// output depths
	localparam logic [2:0] OUT_1BPP  = 3'd0;
	localparam logic [2:0] OUT_8BPP  = 3'd1;
	localparam logic [2:0] OUT_16BPP = 3'd2;
	localparam logic [2:0] OUT_24BPP = 3'd3;
	localparam logic [2:0] OUT_32BPP = 3'd4;

	// source kinds
	localparam logic [1:0] SRC_MONO   = 2'd0;
	localparam logic [1:0] SRC_BGR    = 2'd1;
	localparam logic [1:0] SRC_RGB555 = 2'd2;

	typedef struct packed {
		logic        func;
		logic [13:0] byte_addr;
		logic [7:0]  byte_data;
		logic [7:0]  out_row;
		logic [7:0]  out_col;
	} in_item_t;

	typedef struct packed {
		logic [31:0] pixel_bytes;
		logic [2:0]  byte_count;
		logic        mono_bit;
		logic        mono_valid;
	} out_item_t;

	// divide by three through a reciprocal, exact for x up to 767
	function automatic logic [7:0] div3(input logic [9:0] x);
		logic [19:0] m;
		m = {10'd0, x} * 20'd683;
		return m[18:11];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/icon_scale_pixel_convert_unit.sv =====
`default_nettype none

// Nearest-neighbour icon scaler with pixel format conversion. A write transfer stores one
// source byte; a request transfer names an output row and column and yields one result
// pixel, converted from the configured source format to the configured output depth.
// Requests made while src_row_bytes is zero give no result. The block takes one item
// per clock unless an output stall has backed the pipeline up to the input. A request
// passes through registered steps for the position products, the bounds check, the
// address multiply, the address add with the memory read, and the format conversion
// into the output register. The source image sits in four byte-interleaved synchronous
// banks, so the up to three consecutive bytes of one pixel come out of one read.
// Writes travel down the same pipeline as requests and land in the store at the read
// stage, so every request sees exactly the writes transferred before it. Source bytes
// must be written before they are requested; the store has no reset and no clearing pass.
// The user must write configuration only while no item is in flight; it is not enforced.
module icon_scale_pixel_convert_unit (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [2:0]           wr_index,
	input  wire logic [23:0]          wr_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire iscpc_pkg::in_item_t  in_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output iscpc_pkg::out_item_t      out_data
);

	// configuration registers
	logic [2:0]  out_format_q;
	logic [1:0]  src_format_q;
	logic [2:0]  src_pixel_bytes_q;
	logic [8:0]  src_width_q;
	logic [8:0]  src_height_q;
	logic [10:0] src_row_bytes_q;
	logic [23:0] scale_q16_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_format_q      <= iscpc_pkg::OUT_32BPP;
			src_format_q      <= iscpc_pkg::SRC_BGR;
			src_pixel_bytes_q <= 3'd4;
			src_width_q       <= 9'd32;
			src_height_q      <= 9'd32;
			src_row_bytes_q   <= 11'd128;
			scale_q16_q       <= 24'd65536;
		end else if (wr_en) begin
			unique case (wr_index)
				iscpc_pkg::CFG_OUT_FORMAT:      out_format_q      <= wr_data[2:0];
				iscpc_pkg::CFG_SRC_FORMAT:      src_format_q      <= wr_data[1:0];
				iscpc_pkg::CFG_SRC_PIXEL_BYTES: src_pixel_bytes_q <= wr_data[2:0];
				iscpc_pkg::CFG_SRC_WIDTH:       src_width_q       <= wr_data[8:0];
				iscpc_pkg::CFG_SRC_HEIGHT:      src_height_q      <= wr_data[8:0];
				iscpc_pkg::CFG_SRC_ROW_BYTES:   src_row_bytes_q   <= wr_data[10:0];
				iscpc_pkg::CFG_SCALE_Q16:       scale_q16_q       <= wr_data;
				default: ;
			endcase
		end
	end

	// pipeline state
	logic        v_s1, v_s2, v_s3, v_s4;
	logic        func_s1, func_s2, func_s3;
	logic [13:0] waddr_s1, waddr_s2, waddr_s3;
	logic [7:0]  wdata_s1, wdata_s2, wdata_s3;
	logic [31:0] prodx_s1, prody_s1;
	logic        inside_s2, inside_s3;
	logic [8:0]  posx_s2, posy_s2;
	logic [2:0]  bit_s3, bit_s4;
	logic [19:0] base_s3;
	logic [11:0] off_s3;
	logic [1:0]  lo_s4;
	logic [2:0]  mask_s4;
	logic [7:0]  rd_s4 [iscpc_pkg::BANKS];

	logic                 out_valid_q;
	iscpc_pkg::out_item_t out_data_q;

	// load enables: a stage loads when empty or when the one after it loads
	logic ld_out, ld_4, ld_3, ld_2, ld_1, in_take;

	assign ld_out  = !out_valid_q || !out_stall;
	assign ld_4    = !v_s4 || ld_out;
	assign ld_3    = !v_s3 || ld_4;
	assign ld_2    = !v_s2 || ld_3;
	assign ld_1    = !v_s1 || ld_2;
	assign in_stall = !ld_1;
	assign in_take  = in_valid && ld_1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld_1) begin
				v_s1 <= in_take && (in_data.func == iscpc_pkg::FUNC_WRITE ||
					src_row_bytes_q != 11'd0);
			end
			if (ld_2) begin
				v_s2 <= v_s1;
			end
			if (ld_3) begin
				v_s3 <= v_s2;
			end
			if (ld_4) begin
				v_s4 <= v_s3 && func_s3 == iscpc_pkg::FUNC_REQUEST;
			end
			if (ld_out) begin
				out_valid_q <= v_s4;
			end
		end
	end

	// stage 1: position products
	always_ff @(posedge clk) begin
		if (ld_1) begin
			func_s1  <= in_data.func;
			waddr_s1 <= in_data.byte_addr;
			wdata_s1 <= in_data.byte_data;
			prodx_s1 <= {24'd0, in_data.out_col} * {8'd0, scale_q16_q};
			prody_s1 <= {24'd0, in_data.out_row} * {8'd0, scale_q16_q};
		end
	end

	// stage 2: source position and bounds
	always_ff @(posedge clk) begin
		if (ld_2) begin
			func_s2   <= func_s1;
			waddr_s2  <= waddr_s1;
			wdata_s2  <= wdata_s1;
			inside_s2 <= prodx_s1[31:16] < {7'd0, src_width_q} &&
				prody_s1[31:16] < {7'd0, src_height_q};
			posx_s2   <= prodx_s1[24:16];
			posy_s2   <= prody_s1[24:16];
		end
	end

	// stage 3: row base and offset within the row
	always_ff @(posedge clk) begin
		if (ld_3) begin
			func_s3   <= func_s2;
			waddr_s3  <= waddr_s2;
			wdata_s3  <= wdata_s2;
			inside_s3 <= inside_s2;
			bit_s3    <= posx_s2[2:0];
			base_s3   <= {11'd0, posy_s2} * {9'd0, src_row_bytes_q};
			if (src_format_q == iscpc_pkg::SRC_MONO) begin
				off_s3 <= {6'd0, posx_s2[8:3]};
			end else begin
				off_s3 <= {3'd0, posx_s2} * {9'd0, src_pixel_bytes_q};
			end
		end
	end

	// byte address of the pixel and the bank rows that hold its bytes
	localparam int PIX_ADDR_W_L = iscpc_pkg::PIX_ADDR_W;
	logic [PIX_ADDR_W_L-1:0] pix_addr;
	logic [PIX_ADDR_W_L-1:0] rd_row_full [iscpc_pkg::BANKS];
	logic [2:0] byte_ok;
	logic       store_wr;
	logic [1:0] wr_bank;
	logic [iscpc_pkg::ROW_W-1:0] wr_row;

	always_comb begin
		pix_addr = PIX_ADDR_W_L'(base_s3) + PIX_ADDR_W_L'(off_s3);
		for (int k = 0; k < iscpc_pkg::BANKS; k++) begin
			rd_row_full[k] = (pix_addr >> 2) +
				PIX_ADDR_W_L'(2'(k) < pix_addr[1:0]);
		end
		for (int j = 0; j < 3; j++) begin
			byte_ok[j] = inside_s3 &&
				(pix_addr + PIX_ADDR_W_L'(j)) < PIX_ADDR_W_L'(iscpc_pkg::SRC_BYTES);
		end
	end

	// writes land at the read stage so request order is kept
	assign store_wr = v_s3 && func_s3 == iscpc_pkg::FUNC_WRITE && ld_4 &&
		{8'd0, waddr_s3} < PIX_ADDR_W_L'(iscpc_pkg::SRC_BYTES);
	assign wr_bank  = waddr_s3[1:0];
	assign wr_row   = iscpc_pkg::ROW_W'(waddr_s3 >> 2);

	// four byte-interleaved banks, one write and one read port each
	for (genvar k = 0; k < iscpc_pkg::BANKS; k++) begin : g_bank
		logic [7:0] mem [iscpc_pkg::BANK_DEPTH];

		always_ff @(posedge clk) begin
			if (store_wr && wr_bank == 2'(k)) begin
				mem[wr_row] <= wdata_s3;
			end
			if (ld_4) begin
				rd_s4[k] <= mem[iscpc_pkg::ROW_W'(rd_row_full[k])];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_4) begin
			lo_s4   <= pix_addr[1:0];
			mask_s4 <= byte_ok;
			bit_s4  <= bit_s3;
		end
	end

	// stage 4: gather bytes and convert
	logic [7:0]  b0, b1, b2;
	logic        set_bit;
	logic [14:0] c16;
	logic [15:0] c555;
	logic [4:0]  f0, f1, f2;
	logic [7:0]  avg;
	iscpc_pkg::out_item_t conv;

	always_comb begin
		b0 = mask_s4[0] ? rd_s4[lo_s4] : 8'd0;
		b1 = mask_s4[1] ? rd_s4[lo_s4 + 2'd1] : 8'd0;
		b2 = mask_s4[2] ? rd_s4[lo_s4 + 2'd2] : 8'd0;
		set_bit = b0[bit_s4];
		c16  = {b0[7:3], b1[7:3], b2[7:3]};
		c555 = {b0, b1};
		f0 = c555[4:0];
		f1 = c555[9:5];
		f2 = c555[14:10];
		if (src_format_q == iscpc_pkg::SRC_RGB555) begin
			avg = iscpc_pkg::div3({5'd0, f0} + {5'd0, f1} + {5'd0, f2});
		end else begin
			avg = iscpc_pkg::div3({2'd0, b0} + {2'd0, b1} + {2'd0, b2});
		end
		conv = '0;
		case (src_format_q)
			iscpc_pkg::SRC_MONO: begin
				case (out_format_q)
					iscpc_pkg::OUT_1BPP: begin
						conv.mono_bit   = !set_bit;
						conv.mono_valid = 1'b1;
					end
					iscpc_pkg::OUT_8BPP: begin
						conv.byte_count  = 3'd1;
						conv.pixel_bytes = set_bit ? 32'd0 : 32'h0000_00ff;
					end
					iscpc_pkg::OUT_16BPP: begin
						conv.byte_count  = 3'd2;
						conv.pixel_bytes = set_bit ? 32'd0 : 32'h0000_ffff;
					end
					iscpc_pkg::OUT_24BPP: begin
						conv.byte_count  = 3'd3;
						conv.pixel_bytes = set_bit ? 32'd0 : 32'h00ff_ffff;
					end
					iscpc_pkg::OUT_32BPP: begin
						conv.byte_count  = 3'd4;
						conv.pixel_bytes = set_bit ? 32'd0 : 32'h00ff_ffff;
					end
					default: ;
				endcase
			end
			iscpc_pkg::SRC_BGR: begin
				case (out_format_q)
					iscpc_pkg::OUT_1BPP: begin
						conv.mono_bit   = (b0 | b1 | b2) != 8'd0;
						conv.mono_valid = 1'b1;
					end
					iscpc_pkg::OUT_8BPP: begin
						conv.byte_count  = 3'd1;
						conv.pixel_bytes = {24'd0, avg};
					end
					iscpc_pkg::OUT_16BPP: begin
						// high byte first
						conv.byte_count  = 3'd2;
						conv.pixel_bytes = {16'd0, c16[7:0], 1'b0, c16[14:8]};
					end
					iscpc_pkg::OUT_24BPP: begin
						conv.byte_count  = 3'd3;
						conv.pixel_bytes = {8'd0, b2, b1, b0};
					end
					iscpc_pkg::OUT_32BPP: begin
						conv.byte_count  = 3'd4;
						conv.pixel_bytes = {8'd0, b2, b1, b0};
					end
					default: ;
				endcase
			end
			iscpc_pkg::SRC_RGB555: begin
				case (out_format_q)
					iscpc_pkg::OUT_1BPP: begin
						conv.mono_bit   = c555 != 16'd0;
						conv.mono_valid = 1'b1;
					end
					iscpc_pkg::OUT_8BPP: begin
						conv.byte_count  = 3'd1;
						conv.pixel_bytes = {24'd0, avg[5:0], 2'd0};
					end
					iscpc_pkg::OUT_16BPP: begin
						conv.byte_count  = 3'd2;
						conv.pixel_bytes = {16'd0, b1, b0};
					end
					iscpc_pkg::OUT_24BPP: begin
						conv.byte_count  = 3'd3;
						conv.pixel_bytes = {9'd0, f2, 3'd0, f1, 3'd0, f0, 2'd0};
					end
					iscpc_pkg::OUT_32BPP: begin
						conv.byte_count  = 3'd4;
						conv.pixel_bytes = {9'd0, f2, 3'd0, f1, 3'd0, f0, 2'd0};
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (ld_out && v_s4) begin
			out_data_q <= conv;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// checks on the pipeline
	a_take_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> !in_stall)
		else $error("input stalled with an empty first stage");

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && func_s3 == iscpc_pkg::FUNC_WRITE && ld_4) |=> !v_s4)
		else $error("write transfer produced a result");

	a_mono_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.mono_valid && out_data.byte_count != 3'd0))
		else $error("mono result carries bytes");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.byte_count <= 3'd4)
		else $error("byte count beyond four");

endmodule

`default_nettype wire

// ===== dv/icon_scale_pixel_convert_unit_tb.sv =====
`timescale 1ns / 100ps

module icon_scale_pixel_convert_unit_tb;

	localparam logic [1:0] SRC_UNSUPPORTED = 2'd3;
	localparam logic [2:0] OUT_UNDEFINED   = 3'd7;
	localparam int PIPE_SETTLE = 8;
	localparam int DRAIN_LIMIT = 5000;
	localparam int LONG_HOLD   = 400;
	localparam int PHASES      = 14;
	localparam int PHASE_ITEMS = 125;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 wr_en    = 1'b0;
	logic [2:0]           wr_index = '0;
	logic [23:0]          wr_data  = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	iscpc_pkg::in_item_t  in_data  = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	iscpc_pkg::out_item_t out_data;

	icon_scale_pixel_convert_unit uut (.*);

	// shadow copy of the registers and the source store
	logic [2:0]  cfg_out_format  = iscpc_pkg::OUT_32BPP;
	logic [1:0]  cfg_src_format  = iscpc_pkg::SRC_BGR;
	logic [2:0]  cfg_pixel_bytes = 3'd4;
	logic [8:0]  cfg_width       = 9'd32;
	logic [8:0]  cfg_height      = 9'd32;
	logic [10:0] cfg_row_bytes   = 11'd128;
	logic [23:0] cfg_scale       = 24'd65536;
	logic [7:0]  img_bytes [iscpc_pkg::SRC_BYTES];

	iscpc_pkg::in_item_t  item_q [$];
	iscpc_pkg::out_item_t pixel_q [$];
	iscpc_pkg::out_item_t drv_pix;
	iscpc_pkg::out_item_t want;

	int gap_left   = 0;
	int stall_left = 0;
	int hold_left  = 0;
	int hold_reqs  = 0;
	int hold_done  = 0;
	int st_len     = 0;
	bit quiet      = 1'b0;
	int icon_dim   = 32;
	int mism_cnt   = 0;
	int lost_cnt   = 0;
	int n_req      = 0;
	int n_wr       = 0;
	int n_checked  = 0;
	int n_settings = 0;

	// clock
	always #2 clk = ~clk;

	// idle length: mostly none or short, now and then long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// one source byte, zero outside the image or past the store
	function automatic logic [7:0] src_byte(input logic [39:0] a, input logic inb);
		if (!inb || a >= 40'(iscpc_pkg::SRC_BYTES)) return 8'h00;
		return img_bytes[int'(a)];
	endfunction

	// expected pixel for one transfer; returns 1 when a result is due
	function automatic bit convert_pixel(input iscpc_pkg::in_item_t it,
		output iscpc_pkg::out_item_t r);
		logic [31:0] px, py;
		logic [39:0] base, pa;
		logic        inb, hit;
		logic [7:0]  b0, b1, b2;
		logic [15:0] c;
		logic [4:0]  f0, f1, f2;
		logic [9:0]  sum;
		r = '0;
		if (it.func == iscpc_pkg::FUNC_WRITE) begin
			img_bytes[it.byte_addr] = it.byte_data;
			return 1'b0;
		end
		if (cfg_row_bytes == 11'd0) return 1'b0;
		px   = (32'(it.out_col) * 32'(cfg_scale)) >> 16;
		py   = (32'(it.out_row) * 32'(cfg_scale)) >> 16;
		inb  = (px < 32'(cfg_width)) && (py < 32'(cfg_height));
		base = 40'(py) * 40'(cfg_row_bytes);
		pa   = base + 40'(px) * 40'(cfg_pixel_bytes);
		case (cfg_src_format)
			iscpc_pkg::SRC_MONO: begin
				b0  = src_byte(base + 40'(px >> 3), inb);
				hit = b0[px[2:0]];
				case (cfg_out_format)
					iscpc_pkg::OUT_1BPP: begin
						r.mono_bit   = !hit;
						r.mono_valid = 1'b1;
					end
					iscpc_pkg::OUT_8BPP: begin
						r.byte_count  = 3'd1;
						r.pixel_bytes = hit ? 32'h0 : 32'h0000_00FF;
					end
					iscpc_pkg::OUT_16BPP: begin
						r.byte_count  = 3'd2;
						r.pixel_bytes = hit ? 32'h0 : 32'h0000_FFFF;
					end
					iscpc_pkg::OUT_24BPP: begin
						r.byte_count  = 3'd3;
						r.pixel_bytes = hit ? 32'h0 : 32'h00FF_FFFF;
					end
					iscpc_pkg::OUT_32BPP: begin
						r.byte_count  = 3'd4;
						r.pixel_bytes = hit ? 32'h0 : 32'h00FF_FFFF;
					end
					default: ;
				endcase
			end
			iscpc_pkg::SRC_BGR: begin
				b0 = src_byte(pa, inb);
				b1 = src_byte(pa + 40'd1, inb);
				b2 = src_byte(pa + 40'd2, inb);
				case (cfg_out_format)
					iscpc_pkg::OUT_1BPP: begin
						r.mono_bit   = |{b0, b1, b2};
						r.mono_valid = 1'b1;
					end
					iscpc_pkg::OUT_8BPP: begin
						sum = 10'(b0) + 10'(b1) + 10'(b2);
						r.byte_count  = 3'd1;
						r.pixel_bytes = 32'(sum / 10'd3);
					end
					iscpc_pkg::OUT_16BPP: begin
						// high byte of the 5:5:5 word goes first
						c = {1'b0, b0[7:3], b1[7:3], b2[7:3]};
						r.byte_count  = 3'd2;
						r.pixel_bytes = {16'h0, c[7:0], c[15:8]};
					end
					iscpc_pkg::OUT_24BPP: begin
						r.byte_count  = 3'd3;
						r.pixel_bytes = {8'h0, b2, b1, b0};
					end
					iscpc_pkg::OUT_32BPP: begin
						r.byte_count  = 3'd4;
						r.pixel_bytes = {8'h0, b2, b1, b0};
					end
					default: ;
				endcase
			end
			iscpc_pkg::SRC_RGB555: begin
				b0 = src_byte(pa, inb);
				b1 = src_byte(pa + 40'd1, inb);
				c  = {b0, b1};
				f0 = c[4:0];
				f1 = c[9:5];
				f2 = c[14:10];
				case (cfg_out_format)
					iscpc_pkg::OUT_1BPP: begin
						r.mono_bit   = (c != 16'h0);
						r.mono_valid = 1'b1;
					end
					iscpc_pkg::OUT_8BPP: begin
						sum = 10'(f0) + 10'(f1) + 10'(f2);
						r.byte_count  = 3'd1;
						r.pixel_bytes = 32'(sum / 10'd3) << 2;
					end
					iscpc_pkg::OUT_16BPP: begin
						r.byte_count  = 3'd2;
						r.pixel_bytes = {16'h0, b1, b0};
					end
					iscpc_pkg::OUT_24BPP: begin
						r.byte_count  = 3'd3;
						r.pixel_bytes = {9'h0, f2, 3'b000, f1, 3'b000, f0, 2'b00};
					end
					iscpc_pkg::OUT_32BPP: begin
						r.byte_count  = 3'd4;
						r.pixel_bytes = {9'h0, f2, 3'b000, f1, 3'b000, f0, 2'b00};
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		return 1'b1;
	endfunction

	// input driver: next item on a free slot, random gaps after each transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				if (convert_pixel(in_data, drv_pix)) pixel_q.push_back(drv_pix);
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (item_q.size() != 0) begin
					in_data  <= item_q.pop_front();
					in_valid <= 1'b1;
					gap_left <= quiet ? 0 : idle_len();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output monitor: compare each transfer, then pick the next stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
			hold_left  <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				n_checked++;
				if (pixel_q.size() == 0) begin
					$error("result with no pending request: pixel_bytes %h",
						out_data.pixel_bytes);
					mism_cnt++;
				end else begin
					want = pixel_q.pop_front();
					if (out_data.pixel_bytes !== want.pixel_bytes) begin
						$error("pixel_bytes expected %h actual %h",
							want.pixel_bytes, out_data.pixel_bytes);
						mism_cnt++;
					end
					if (out_data.byte_count !== want.byte_count) begin
						$error("byte_count expected %0d actual %0d",
							want.byte_count, out_data.byte_count);
						mism_cnt++;
					end
					if (out_data.mono_bit !== want.mono_bit) begin
						$error("mono_bit expected %b actual %b",
							want.mono_bit, out_data.mono_bit);
						mism_cnt++;
					end
					if (out_data.mono_valid !== want.mono_valid) begin
						$error("mono_valid expected %b actual %b",
							want.mono_valid, out_data.mono_valid);
						mism_cnt++;
					end
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else if (hold_reqs != hold_done) begin
				// long hold so that the pipeline backs up into the input
				hold_done <= hold_done + 1;
				hold_left <= LONG_HOLD - 1;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_stall  <= 1'b1;
			end else begin
				st_len = quiet ? 0 : idle_len();
				stall_left <= (st_len > 0) ? st_len - 1 : 0;
				out_stall  <= (st_len > 0);
			end
		end
	end

	task automatic push_write(input logic [13:0] addr, input logic [7:0] data);
		iscpc_pkg::in_item_t it;
		it           = iscpc_pkg::in_item_t'({$urandom, $urandom});
		it.func      = iscpc_pkg::FUNC_WRITE;
		it.byte_addr = addr;
		it.byte_data = data;
		item_q.push_back(it);
		n_wr++;
	endtask

	task automatic push_request(input logic [7:0] row, input logic [7:0] col);
		iscpc_pkg::in_item_t it;
		it         = iscpc_pkg::in_item_t'({$urandom, $urandom});
		it.func    = iscpc_pkg::FUNC_REQUEST;
		it.out_row = row;
		it.out_col = col;
		item_q.push_back(it);
		n_req++;
	endtask

	// wait for every item to be transferred and every result to arrive
	task automatic wait_idle();
		int spin;
		while (item_q.size() != 0 || in_valid) @(negedge clk);
		spin = 0;
		while (pixel_q.size() != 0 && spin < DRAIN_LIMIT) begin
			@(negedge clk);
			spin++;
		end
		if (pixel_q.size() != 0) begin
			$error("%0d expected results never arrived", pixel_q.size());
			lost_cnt += pixel_q.size();
			pixel_q.delete();
		end
		repeat (PIPE_SETTLE) @(posedge clk);
	endtask

	// register write, only called with the block idle
	task automatic set_reg(input logic [2:0] idx, input logic [23:0] val);
		case (idx)
			iscpc_pkg::CFG_OUT_FORMAT:      cfg_out_format  = val[2:0];
			iscpc_pkg::CFG_SRC_FORMAT:      cfg_src_format  = val[1:0];
			iscpc_pkg::CFG_SRC_PIXEL_BYTES: cfg_pixel_bytes = val[2:0];
			iscpc_pkg::CFG_SRC_WIDTH:       cfg_width       = val[8:0];
			iscpc_pkg::CFG_SRC_HEIGHT:      cfg_height      = val[8:0];
			iscpc_pkg::CFG_SRC_ROW_BYTES:   cfg_row_bytes   = val[10:0];
			iscpc_pkg::CFG_SCALE_Q16:       cfg_scale       = val;
			default: ;
		endcase
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		n_settings++;
	endtask

	task automatic retune(input logic [2:0] idx, input logic [23:0] val);
		wait_idle();
		set_reg(idx, val);
	endtask

	// new setting for one random phase, the first three at the extremes
	task automatic random_setting(input int ph);
		logic [2:0]  of, pb;
		logic [1:0]  sf;
		logic [8:0]  w, h;
		logic [10:0] rb;
		logic [23:0] sc;
		int          r, big, row_len;
		of = ($urandom_range(0, 9) == 0) ? 3'(iscpc_pkg::OUT_32BPP + $urandom_range(1, 3))
			: 3'($urandom_range(iscpc_pkg::OUT_1BPP, iscpc_pkg::OUT_32BPP));
		sf = ($urandom_range(0, 9) == 0) ? SRC_UNSUPPORTED
			: 2'($urandom_range(iscpc_pkg::SRC_MONO, iscpc_pkg::SRC_RGB555));
		pb = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(2, 4)) : 3'($urandom_range(0, 7));
		r = $urandom_range(0, 99);
		w = (r < 70) ? 9'($urandom_range(1, 64)) :
			(r < 90) ? 9'($urandom_range(65, 256)) : 9'($urandom_range(0, 511));
		r = $urandom_range(0, 99);
		h = (r < 70) ? 9'($urandom_range(1, 64)) :
			(r < 90) ? 9'($urandom_range(65, 256)) : 9'($urandom_range(0, 511));
		row_len = (sf == iscpc_pkg::SRC_MONO) ? (int'(w) + 7) / 8 : int'(w) * int'(pb);
		row_len += $urandom_range(0, 7);
		r = $urandom_range(0, 99);
		rb = (r < 5) ? 11'd0 : (r < 15) ? 11'($urandom_range(0, 2047))
			: 11'((row_len > 2047) ? 2047 : row_len);
		icon_dim = $urandom_range(8, 256);
		big = (w > h) ? int'(w) : int'(h);
		big = big * 65536 / icon_dim;
		sc = ($urandom_range(0, 9) == 0) ? 24'($urandom_range(0, 24'hFF_FFFF))
			: 24'((big > 24'hFF_FFFF) ? 24'hFF_FFFF : big);
		if (ph == 0) begin
			// smallest image, every request on one pixel
			w = 9'd1; h = 9'd1; rb = 11'd1; pb = 3'd2; sc = 24'd0; icon_dim = 16;
		end else if (ph == 1) begin
			w = 9'd256; h = 9'd256; rb = 11'd1024; pb = 3'd4; sc = 24'd65536;
			icon_dim = 256;
		end else if (ph == 2) begin
			// every size and scale register at its full width
			w = 9'd511; h = 9'd511; rb = 11'd2047; pb = 3'd7; sc = 24'hFF_FFFF;
			icon_dim = 256;
		end
		wait_idle();
		set_reg(iscpc_pkg::CFG_OUT_FORMAT, 24'(of));
		set_reg(iscpc_pkg::CFG_SRC_FORMAT, 24'(sf));
		set_reg(iscpc_pkg::CFG_SRC_PIXEL_BYTES, 24'(pb));
		set_reg(iscpc_pkg::CFG_SRC_WIDTH, 24'(w));
		set_reg(iscpc_pkg::CFG_SRC_HEIGHT, 24'(h));
		set_reg(iscpc_pkg::CFG_SRC_ROW_BYTES, 24'(rb));
		set_reg(iscpc_pkg::CFG_SCALE_Q16, sc);
	endtask

	function automatic logic [7:0] pick_coord();
		if ($urandom_range(0, 99) < 85) return 8'($urandom_range(0, icon_dim - 1));
		return 8'($urandom_range(0, 255));
	endfunction

	// stimulus and end of run
	initial begin : stimulus
		int i, k, span;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// fill the whole store once so that no request reads an unwritten byte
		quiet = 1'b1;
		for (i = 0; i < iscpc_pkg::SRC_BYTES; i++) push_write(14'(i), 8'($urandom));
		wait_idle();
		quiet = 1'b0;

		// directed: known pixels under the reset setting
		push_write(14'd0, 8'hFF);
		push_write(14'd1, 8'h00);
		push_write(14'd2, 8'h80);
		push_write(14'h3FFF, 8'h00);
		push_write(14'd128, 8'h00);
		push_write(14'd129, 8'h00);
		push_write(14'd130, 8'h00);
		push_request(8'd0, 8'd0);
		push_request(8'd1, 8'd0);
		push_request(8'd255, 8'd255);
		// every output depth from a colour source
		retune(iscpc_pkg::CFG_OUT_FORMAT, 24'(iscpc_pkg::OUT_24BPP));
		push_request(8'd0, 8'd0);
		retune(iscpc_pkg::CFG_OUT_FORMAT, 24'(iscpc_pkg::OUT_16BPP));
		push_request(8'd0, 8'd0);
		retune(iscpc_pkg::CFG_OUT_FORMAT, 24'(iscpc_pkg::OUT_8BPP));
		push_request(8'd0, 8'd0);
		retune(iscpc_pkg::CFG_OUT_FORMAT, 24'(iscpc_pkg::OUT_1BPP));
		push_request(8'd0, 8'd0);
		push_request(8'd1, 8'd0);
		// mono source, set and clear bit
		retune(iscpc_pkg::CFG_SRC_FORMAT, 24'(iscpc_pkg::SRC_MONO));
		push_request(8'd0, 8'd0);
		push_request(8'd0, 8'd8);
		retune(iscpc_pkg::CFG_SRC_FORMAT, 24'(iscpc_pkg::SRC_RGB555));
		push_request(8'd0, 8'd0);
		// unsupported source and undefined depth give empty results
		retune(iscpc_pkg::CFG_SRC_FORMAT, 24'(SRC_UNSUPPORTED));
		push_request(8'd0, 8'd0);
		retune(iscpc_pkg::CFG_SRC_FORMAT, 24'(iscpc_pkg::SRC_BGR));
		set_reg(iscpc_pkg::CFG_OUT_FORMAT, 24'(OUT_UNDEFINED));
		push_request(8'd0, 8'd0);
		// zero row length gives no result
		retune(iscpc_pkg::CFG_OUT_FORMAT, 24'(iscpc_pkg::OUT_32BPP));
		set_reg(iscpc_pkg::CFG_SRC_ROW_BYTES, 24'd0);
		push_request(8'd0, 8'd0);
		// large image: rows past the end of the store read zero
		retune(iscpc_pkg::CFG_SRC_ROW_BYTES, 24'd1024);
		set_reg(iscpc_pkg::CFG_SRC_WIDTH, 24'd256);
		set_reg(iscpc_pkg::CFG_SRC_HEIGHT, 24'd256);
		push_request(8'd255, 8'd255);
		push_request(8'd15, 8'd0);
		retune(iscpc_pkg::CFG_SCALE_Q16, 24'hFF_FFFF);
		push_request(8'd1, 8'd1);
		push_request(8'd0, 8'd255);
		// odd pixel sizes
		retune(iscpc_pkg::CFG_SCALE_Q16, 24'd65536);
		set_reg(iscpc_pkg::CFG_SRC_PIXEL_BYTES, 24'd0);
		push_request(8'd2, 8'd3);
		retune(iscpc_pkg::CFG_SRC_PIXEL_BYTES, 24'd7);
		push_request(8'd2, 8'd3);

		// random phases, one setting each
		for (i = 0; i < PHASES; i++) begin
			random_setting(i);
			quiet = (i % 4 == 3);
			span = int'(cfg_height) * int'(cfg_row_bytes) + 3;
			if (span > iscpc_pkg::SRC_BYTES - 1) span = iscpc_pkg::SRC_BYTES - 1;
			for (k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(0, 4) == 0) begin
					if ($urandom_range(0, 1) == 0)
						push_write(14'($urandom_range(0, span)), 8'($urandom));
					else
						push_write(14'($urandom_range(0, iscpc_pkg::SRC_BYTES - 1)),
							8'($urandom));
				end else begin
					push_request(pick_coord(), pick_coord());
				end
			end
			if (i == 5) hold_reqs++;
		end
		quiet = 1'b0;
		wait_idle();

		$display("sent %0d pixel requests and %0d store writes over %0d register writes",
			n_req, n_wr, n_settings);
		$display("checked %0d results across all source kinds and depths, with a long hold",
			n_checked);
		if (mism_cnt == 0 && lost_cnt == 0) begin
			$display("icon_scale_pixel_convert_unit verification clean");
		end else begin
			$display("icon_scale_pixel_convert_unit verification failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#15000000;
		$display("icon_scale_pixel_convert_unit verification failed");
		$finish;
	end

endmodule
